/* hw/rtl/moi_pkg.sv */
// Shared types, constants and elaboration-time functions for the motor overload integrator.
// No dependencies; every other file in this block refers to it by scoped names.
package moi_pkg;

  localparam int ADC_BITS_DEF = 13;
  localparam int ACC_BITS_DEF = 48;
  localparam int INV_FRAC_BITS_DEF = 16;

  localparam int STAMP_W = 32;
  localparam int ADC_FIELD_W = 16;
  localparam int LEVEL_W = 48;
  localparam int OUT_W = 104;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE = 48'h0000_0001_0000;

  // Amps = floor(adc * 1611328 / 10^8); both terms share a factor of 64.
  localparam logic [63:0] AMP_NUM = 64'd1611328;
  localparam logic [63:0] AMP_DEN = 64'd100000000;
  localparam int AMP_MUL = 25177;
  localparam int AMP_DIV = 1562500;

  // The amps conversion multiplies by a rounded-up reciprocal and keeps the bits above
  // AMP_SHIFT; this is exact for every ADC code of up to 16 bits.
  localparam int AMP_SHIFT = 40;
  localparam logic [63:0] AMP_RECIP =
    ((64'd1 << AMP_SHIFT) * 64'(AMP_MUL) + 64'(AMP_DIV) - 64'd1) / 64'(AMP_DIV);

  localparam logic [63:0] KNOM_SQ_NUM = 64'd40752708129;
  localparam logic [63:0] KNOM_SQ_DEN = 64'd10000000000;
  localparam logic [63:0] KNOM_NUM = 64'd201873;
  localparam logic [63:0] KNOM_DEN = 64'd100000;
  localparam logic [63:0] T_WEIGHT_X10 = 64'd422;

  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [ADC_FIELD_W-1:0] adc_t;
  typedef logic [OUT_W-1:0] out_t;

  typedef struct packed {
    stamp_t dt;
    stamp_t since;
    logic   check;
    adc_t   left_adc;
    adc_t   right_adc;
  } moi_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AMP,
    ST_CPROD,
    ST_CACC,
    ST_AVG,
    ST_ROM,
    ST_MUL,
    ST_LVL,
    ST_OUT
  } back_state_t;

  function automatic logic [63:0] amp_max(input int adc_bits);
    logic [63:0] mask;
    mask = (64'd1 << adc_bits) - 64'd1;
    return (mask * AMP_NUM) / AMP_DEN;
  endfunction

  // Heating rate 1/ton in Q.ifb for a given average current, built from a
  // series expansion of the logarithm with long divisions done bit by bit.
  function automatic logic [63:0] rate_entry(input logic [63:0] avg, input int ifb);
    logic [63:0]  den;
    logic [63:0]  r;
    logic [63:0]  x;
    logic [63:0]  s;
    logic [63:0]  t;
    logic [63:0]  d;
    logic [63:0]  q;
    logic [63:0]  tq;
    logic [63:0]  tr;
    logic [127:0] p;
    int           i;
    int           j;
    if (avg * KNOM_DEN <= KNOM_NUM) begin
      return 64'd0;
    end
    den = avg * avg * KNOM_SQ_DEN;
    r = KNOM_SQ_NUM;
    x = '0;
    for (i = 0; i < 64; i++) begin
      r = r << 1;
      x = x << 1;
      if (r >= den) begin
        r = r - den;
        x[0] = 1'b1;
      end
    end
    t = x;
    s = '0;
    for (i = 1; i <= 64; i++) begin
      if (t != 64'd0) begin
        tq = '0;
        tr = '0;
        for (j = 63; j >= 0; j--) begin
          tr = {tr[62:0], t[j]};
          tq = {tq[62:0], 1'b0};
          if (tr >= 64'(i)) begin
            tr = tr - 64'(i);
            tq[0] = 1'b1;
          end
        end
        s = s + tq;
        p = {64'd0, t} * {64'd0, x};
        t = p[127:64];
      end
    end
    d = T_WEIGHT_X10 * (s >> 16);
    if (d == 64'd0) begin
      return 64'd0;
    end
    q = '0;
    r = 64'd10;
    for (i = 0; i < ifb + 48; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

endpackage

/* hw/rtl/moi_front.sv */
// Front end: takes samples from the input stream, holds the timing state and the
// check interval register, and queues each sample as a classified work item.
// Depends on moi_pkg.
module moi_front #(
  parameter int ADC_BITS = moi_pkg::ADC_BITS_DEF,
  parameter int IN_W = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [IN_W-1:0]     s_axis_tdata,
  input  logic                cfg_wr_en,
  input  logic [30:0]         cfg_wr_data,
  input  logic                q_full,
  output logic                push,
  output moi_pkg::moi_item_t  push_item
);

  logic [30:0]     check_interval;
  moi_pkg::stamp_t last_sample_time;
  moi_pkg::stamp_t last_check_time;
  moi_pkg::stamp_t now;
  moi_pkg::stamp_t dt;
  moi_pkg::stamp_t since;
  logic            check;

  assign now   = s_axis_tdata[31:0];
  assign dt    = now - last_sample_time;
  assign since = now - last_check_time;
  assign check = since > {1'b0, check_interval};

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  assign push_item.dt        = dt;
  assign push_item.since     = since;
  assign push_item.check     = check;
  assign push_item.left_adc  = moi_pkg::adc_t'(s_axis_tdata[32 +: ADC_BITS]);
  assign push_item.right_adc = moi_pkg::adc_t'(s_axis_tdata[32 + ADC_BITS +: ADC_BITS]);

  always_ff @(posedge clk) begin
    if (rst) begin
      check_interval   <= '0;
      last_sample_time <= '0;
      last_check_time  <= '0;
    end else begin
      if (cfg_wr_en) begin
        check_interval <= cfg_wr_data;
      end
      if (push) begin
        last_sample_time <= now;
        if (check) begin
          last_check_time <= now;
        end
      end
    end
  end

endmodule

/* hw/rtl/moi_queue.sv */
// Short work queue between the front end and the arithmetic back end.
// Depends on moi_pkg for the item type and the depth, which is a power of two.
module moi_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  moi_pkg::moi_item_t push_item,
  output logic               full,
  input  logic               pop,
  output moi_pkg::moi_item_t pop_item,
  output logic               valid
);

  localparam int PTR_W = $clog2(moi_pkg::QUEUE_DEPTH);

  moi_pkg::moi_item_t slots [moi_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;

  assign full     = count == (PTR_W + 1)'(moi_pkg::QUEUE_DEPTH);
  assign valid    = count != '0;
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/moi_back.sv */
// Back end: a sequencer with one shared restoring divider, a digit-serial multiplier
// and the heating-rate ROM, which holds charges and levels and drives the result register.
// Depends on moi_pkg.
module moi_back #(
  parameter int ADC_BITS = moi_pkg::ADC_BITS_DEF,
  parameter int ACC_BITS = moi_pkg::ACC_BITS_DEF,
  parameter int INV_FRAC_BITS = moi_pkg::INV_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  input  moi_pkg::moi_item_t       q_item,
  output logic                     q_pop,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [moi_pkg::OUT_W-1:0] m_axis_tdata,
  output logic                     m_axis_tuser
);

  localparam logic [63:0] AMP_MAX = moi_pkg::amp_max(ADC_BITS);
  localparam int AMP_COUNT = int'(AMP_MAX) + 1;
  localparam int AMP_BITS = $clog2(AMP_COUNT);
  localparam int CNT_W = $clog2(AMP_BITS);
  localparam int INV_W = INV_FRAC_BITS + 13;
  localparam int NCH = (INV_W + 7) / 8;
  localparam int ENT_W = NCH * 8;
  localparam int MCNT_W = $clog2(NCH);
  localparam int PROD_W = moi_pkg::STAMP_W + ENT_W;
  localparam int INC_W = PROD_W + 8;
  localparam int LSUM_W = INC_W + 1;
  localparam int SHR = (INV_FRAC_BITS >= 16) ? INV_FRAC_BITS - 16 : 0;
  localparam int SHL = (INV_FRAC_BITS < 16) ? 16 - INV_FRAC_BITS : 0;
  localparam int DIV_W = (ACC_BITS > moi_pkg::STAMP_W + AMP_BITS) ?
                         ACC_BITS : moi_pkg::STAMP_W + AMP_BITS;
  localparam int CPROD_W = moi_pkg::STAMP_W + AMP_BITS;
  localparam int CSUM_W = ((ACC_BITS > CPROD_W) ? ACC_BITS : CPROD_W) + 1;
  localparam int AMP_PROD_W = moi_pkg::ADC_FIELD_W + moi_pkg::AMP_SHIFT;

  typedef logic [DIV_W-1:0]  dword_t;
  typedef logic [ENT_W-1:0]  ent_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [INC_W-1:0]  inc_t;
  typedef logic [LSUM_W-1:0] lsum_t;
  typedef logic [CSUM_W-1:0] csum_t;

  localparam logic [AMP_BITS-1:0] AMP_TOP = AMP_BITS'(AMP_MAX);
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(AMP_BITS - 1);
  localparam logic [MCNT_W-1:0] MCNT_TOP = MCNT_W'(NCH - 1);
  localparam logic [ACC_BITS-1:0] CHARGE_MAX = '1;

  logic [INV_W-1:0] rate_rom [AMP_COUNT];

  for (genvar g = 0; g < AMP_COUNT; g++) begin : g_rate_rom
    localparam logic [63:0] RATE = moi_pkg::rate_entry(64'(g), INV_FRAC_BITS);
    assign rate_rom[g] = RATE[INV_W-1:0];
  end

  moi_pkg::back_state_t state;
  moi_pkg::back_state_t state_next;
  moi_pkg::moi_item_t   item;
  logic                 ch;
  dword_t               rem;
  dword_t               dsh;
  logic [AMP_BITS-1:0]  quo;
  logic [CNT_W-1:0]     cnt;
  logic                 sat;
  logic [CPROD_W-1:0]   cprod;
  ent_t                 entry;
  prod_t                acc;
  logic [MCNT_W-1:0]    mcnt;
  logic [ACC_BITS-1:0]  left_charge;
  logic [ACC_BITS-1:0]  right_charge;
  logic [moi_pkg::LEVEL_W-1:0] left_level;
  logic [moi_pkg::LEVEL_W-1:0] right_level;
  logic                 out_valid;
  moi_pkg::out_t        out_data;
  logic                 out_user;
  logic                 out_load;

  moi_pkg::adc_t        amp_adc;
  logic [AMP_PROD_W-1:0] amp_prod;
  logic [AMP_BITS-1:0]  amp_val;
  logic [ACC_BITS-1:0]  avg_src;
  dword_t               avg_num;
  dword_t               avg_dsh;
  logic                 avg_sat;
  logic                 div_ge;
  logic [AMP_BITS-1:0]  avg_idx;
  logic [ACC_BITS-1:0]  charge_cur;
  csum_t                csum;
  logic [ACC_BITS-1:0]  charge_new;
  logic [39:0]          mul_chunk;
  logic [moi_pkg::LEVEL_W-1:0] level_cur;
  inc_t                 inc;
  lsum_t                lsum;
  logic [moi_pkg::LEVEL_W-1:0] level_new;

  assign amp_adc  = ch ? item.right_adc : item.left_adc;
  assign amp_prod = AMP_PROD_W'(amp_adc[ADC_BITS-1:0]) * AMP_PROD_W'(moi_pkg::AMP_RECIP);
  assign amp_val  = amp_prod[moi_pkg::AMP_SHIFT +: AMP_BITS];

  assign avg_src = (state == moi_pkg::ST_CACC) ? left_charge : right_charge;
  assign avg_num = dword_t'(avg_src);
  assign avg_dsh = dword_t'(item.since) << (AMP_BITS - 1);
  assign avg_sat = avg_num >= (dword_t'(item.since) << AMP_BITS);

  assign div_ge  = rem >= dsh;
  assign avg_idx = (sat || quo > AMP_TOP) ? AMP_TOP : quo;

  assign charge_cur = ch ? right_charge : left_charge;
  assign csum       = csum_t'(charge_cur) + csum_t'(cprod);
  assign charge_new = (csum > csum_t'(CHARGE_MAX)) ? CHARGE_MAX : csum[ACC_BITS-1:0];

  assign mul_chunk = item.since * entry[ENT_W-1 -: 8];

  assign level_cur = ch ? right_level : left_level;
  assign inc       = (inc_t'(acc) << SHL) >> SHR;
  assign lsum      = lsum_t'(inc) + lsum_t'(level_cur);
  assign level_new = (lsum > lsum_t'(moi_pkg::LEVEL_MAX)) ?
                     moi_pkg::LEVEL_MAX : lsum[moi_pkg::LEVEL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= moi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    case (state)
      moi_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = moi_pkg::ST_AMP;
        end
      end
      moi_pkg::ST_AMP: begin
        state_next = moi_pkg::ST_CPROD;
      end
      moi_pkg::ST_CPROD: begin
        state_next = moi_pkg::ST_CACC;
      end
      moi_pkg::ST_CACC: begin
        if (!ch) begin
          state_next = moi_pkg::ST_AMP;
        end else if (item.check) begin
          state_next = moi_pkg::ST_AVG;
        end else begin
          state_next = moi_pkg::ST_OUT;
        end
      end
      moi_pkg::ST_AVG: begin
        if (cnt == '0) begin
          state_next = moi_pkg::ST_ROM;
        end
      end
      moi_pkg::ST_ROM: begin
        state_next = moi_pkg::ST_MUL;
      end
      moi_pkg::ST_MUL: begin
        if (mcnt == '0) begin
          state_next = moi_pkg::ST_LVL;
        end
      end
      moi_pkg::ST_LVL: begin
        state_next = ch ? moi_pkg::ST_OUT : moi_pkg::ST_AVG;
      end
      moi_pkg::ST_OUT: begin
        if (!out_valid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = moi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = moi_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch           <= 1'b0;
      cnt          <= '0;
      mcnt         <= '0;
      left_charge  <= '0;
      right_charge <= '0;
      left_level   <= '0;
      right_level  <= '0;
    end else begin
      case (state)
        moi_pkg::ST_IDLE: begin
          if (q_valid) begin
            item <= q_item;
            ch   <= 1'b0;
          end
        end
        moi_pkg::ST_AMP: begin
          quo <= amp_val;
        end
        moi_pkg::ST_AVG: begin
          rem <= div_ge ? rem - dsh : rem;
          dsh <= dsh >> 1;
          quo <= {quo[AMP_BITS-2:0], div_ge};
          cnt <= cnt - 1'b1;
        end
        moi_pkg::ST_CPROD: begin
          cprod <= item.dt * quo;
        end
        moi_pkg::ST_CACC: begin
          if (ch) begin
            right_charge <= charge_new;
          end else begin
            left_charge <= charge_new;
          end
          if (!ch) begin
            ch <= 1'b1;
          end else if (item.check) begin
            ch  <= 1'b0;
            rem <= avg_num;
            dsh <= avg_dsh;
            sat <= avg_sat;
            quo <= '0;
            cnt <= CNT_TOP;
          end
        end
        moi_pkg::ST_ROM: begin
          entry <= ent_t'(rate_rom[avg_idx]);
          acc   <= '0;
          mcnt  <= MCNT_TOP;
        end
        moi_pkg::ST_MUL: begin
          acc   <= (acc << 8) + prod_t'(mul_chunk);
          entry <= entry << 8;
          mcnt  <= mcnt - 1'b1;
        end
        moi_pkg::ST_LVL: begin
          if (ch) begin
            right_level  <= level_new;
            right_charge <= '0;
          end else begin
            left_level  <= level_new;
            left_charge <= '0;
            ch          <= 1'b1;
            rem         <= avg_num;
            dsh         <= avg_dsh;
            sat         <= avg_sat;
            quo         <= '0;
            cnt         <= CNT_TOP;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= moi_pkg::out_t'({right_level > moi_pkg::LEVEL_ONE,
                                   left_level > moi_pkg::LEVEL_ONE,
                                   right_level, left_level});
      out_user <= item.check;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_user;

endmodule

/* hw/rtl/motor_overload_integrator.sv */
// Two-channel motor thermal overload (i2t) integrator. Each input word carries a
// microsecond timestamp and one current-sense sample per motor; each accepted word gives
// exactly one output word with both overload levels (unsigned Q32.16, saturating), their
// over-limit flags and a flag in tuser that is set when the word ran a check. The back
// end works on one word at a time; a word with a check also runs, for each channel, the
// average division and the rate multiply. The largest amps value has 8 bits with the
// default parameters and the rate entry has 4 byte digits. The amps conversion is a
// single multiply by a reciprocal; the time of a check is set by the shared restoring
// divider, which resolves one quotient bit a cycle for the average, and by the
// byte-serial multiply of elapsed time and heating rate. A four-word queue lets the
// input side keep taking words while the back end works. Depends on moi_pkg, moi_front,
// moi_queue and moi_back.
module motor_overload_integrator #(
  parameter int ADC_BITS = moi_pkg::ADC_BITS_DEF,
  parameter int ACC_BITS = moi_pkg::ACC_BITS_DEF,
  parameter int INV_FRAC_BITS = moi_pkg::INV_FRAC_BITS_DEF,
  localparam int IN_W = ((32 + 2 * ADC_BITS + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // now_us, left_adc, right_adc, zero padding
  input  logic [IN_W-1:0]           s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // left_level, right_level, left_over_limit, right_over_limit, zero padding
  output logic [moi_pkg::OUT_W-1:0] m_axis_tdata,
  // check_done
  output logic                      m_axis_tuser,
  input  logic                      cfg_wr_en,
  input  logic [30:0]               cfg_wr_data
);

  logic               push;
  logic               q_full;
  logic               q_valid;
  logic               q_pop;
  moi_pkg::moi_item_t push_item;
  moi_pkg::moi_item_t q_item;

  moi_front #(
    .ADC_BITS(ADC_BITS),
    .IN_W(IN_W)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .q_full(q_full),
    .push(push),
    .push_item(push_item)
  );

  moi_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_item(push_item),
    .full(q_full),
    .pop(q_pop),
    .pop_item(q_item),
    .valid(q_valid)
  );

  moi_back #(
    .ADC_BITS(ADC_BITS),
    .ACC_BITS(ACC_BITS),
    .INV_FRAC_BITS(INV_FRAC_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_item(q_item),
    .q_pop(q_pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

endmodule

/* hw/rtl/moi_checker.sv */
// Port-level assertions for the motor overload integrator, attached by a bind.
// Depends on moi_pkg and on motor_overload_integrator.
module moi_checker #(
  parameter int ADC_BITS = moi_pkg::ADC_BITS_DEF,
  localparam int IN_W = ((32 + 2 * ADC_BITS + 7) / 8) * 8
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [IN_W-1:0]           s_axis_tdata,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [moi_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                      m_axis_tuser,
  input logic                      cfg_wr_en,
  input logic [30:0]               cfg_wr_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("Stalled output word changed.");

  a_left_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[96] == (m_axis_tdata[47:0] > moi_pkg::LEVEL_ONE))
    else $error("Left over-limit flag disagrees with the left level.");

  a_right_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[97] == (m_axis_tdata[95:48] > moi_pkg::LEVEL_ONE))
    else $error("Right over-limit flag disagrees with the right level.");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("Output word valid straight after reset.");

endmodule

bind motor_overload_integrator moi_checker #(.ADC_BITS(ADC_BITS)) u_moi_checker (.*);
